### rtl/cmfd_pkg.sv
// Shared types and constants for the curve minimum focus detector.
package cmfd_pkg;

  localparam int unsigned IdxW       = 12;
  localparam int unsigned RefW       = 32;
  localparam int unsigned FocMetricW = 32;
  localparam int unsigned ConfW      = 31;
  localparam int unsigned OutTdataW  = 112;

  localparam logic [ConfW-1:0] FallbackConf = 31'd6554;
  localparam logic [ConfW-1:0] ConfMax      = 31'h7FFF_FFFF;

  typedef enum logic [0:0] {
    KIND_POINT = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CONF_NONE     = 2'd0,
    CONF_MEASURED = 2'd1,
    CONF_FALLBACK = 2'd2
  } conf_kind_e;

  // Step controls from the input stage to the tracker.
  typedef struct packed {
    logic point;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic                         focus_valid;
    logic [IdxW-1:0]              focus_idx;
    logic signed [RefW-1:0]       focus_reference;
    logic signed [FocMetricW-1:0] focus_metric;
    logic [ConfW-1:0]             confidence;
    conf_kind_e                   confidence_kind;
    logic                         overflow;
  } result_t;

endpackage

### rtl/cmfd_tracker.sv
// Minimum tracker with neighbor capture and end-of-curve result formation.
module cmfd_tracker #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned METRIC_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cmfd_pkg::ctrl_t                     ctrl_i,
  input  logic signed [METRIC_WIDTH-1:0]      metric_i,
  input  logic                                finite_i,
  input  logic signed [cmfd_pkg::RefW-1:0]    reference_i,
  output cmfd_pkg::result_t                   result_o
);

  localparam int unsigned PcW = $clog2(MAX_POINTS + 1);
  localparam int unsigned FiW = (PcW > cmfd_pkg::IdxW) ? PcW : cmfd_pkg::IdxW;
  localparam int unsigned XW  = (METRIC_WIDTH > cmfd_pkg::FocMetricW) ?
                                METRIC_WIDTH : cmfd_pkg::FocMetricW;
  localparam int unsigned CW  = (METRIC_WIDTH + 2 > 33) ? METRIC_WIDTH + 2 : 33;
  localparam logic [PcW-1:0] CountMax = PcW'(MAX_POINTS);

  logic [PcW-1:0]                 count_q, count_d;
  logic                           have_best_q, have_best_d;
  logic signed [METRIC_WIDTH-1:0] best_q, best_d;
  logic [PcW-1:0]                 best_idx_q, best_idx_d;
  logic signed [cmfd_pkg::RefW-1:0] best_ref_q, best_ref_d;
  logic signed [METRIC_WIDTH-1:0] prev_q, prev_d;
  logic                           prev_fin_q, prev_fin_d;
  logic signed [METRIC_WIDTH-1:0] left_q, left_d;
  logic                           left_fin_q, left_fin_d;
  logic signed [METRIC_WIDTH-1:0] right_q, right_d;
  logic                           right_fin_q, right_fin_d;
  logic                           right_cap_q, right_cap_d;
  logic                           ovf_q, ovf_d;

  logic                           full;
  logic                           cap_right;
  logic                           take;
  logic signed [CW-1:0]           sum;
  logic signed [CW-1:0]           half;
  logic [cmfd_pkg::ConfW-1:0]     measured;
  logic [FiW-1:0]                 idx_ext;
  logic signed [XW-1:0]           best_ext;

  assign full      = (count_q == CountMax);
  assign cap_right = have_best_q && !right_cap_q && (count_q == best_idx_q + PcW'(1));
  assign take      = finite_i && (!have_best_q || (metric_i < best_q));

  always_comb begin
    count_d     = count_q;
    have_best_d = have_best_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_ref_d  = best_ref_q;
    prev_d      = prev_q;
    prev_fin_d  = prev_fin_q;
    left_d      = left_q;
    left_fin_d  = left_fin_q;
    right_d     = right_q;
    right_fin_d = right_fin_q;
    right_cap_d = right_cap_q;
    ovf_d       = ovf_q;
    if (ctrl_i.finish) begin
      count_d     = '0;
      have_best_d = 1'b0;
      prev_fin_d  = 1'b0;
      left_fin_d  = 1'b0;
      right_fin_d = 1'b0;
      right_cap_d = 1'b0;
      ovf_d       = 1'b0;
    end else if (ctrl_i.point) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        if (take) begin
          have_best_d = 1'b1;
          best_d      = metric_i;
          best_idx_d  = count_q;
          best_ref_d  = reference_i;
          left_d      = prev_q;
          left_fin_d  = prev_fin_q;
          right_cap_d = 1'b0;
          right_fin_d = 1'b0;
        end else if (cap_right) begin
          right_d     = metric_i;
          right_fin_d = finite_i;
          right_cap_d = 1'b1;
        end
        prev_d     = metric_i;
        prev_fin_d = finite_i;
        count_d    = count_q + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      have_best_q <= 1'b0;
      prev_fin_q  <= 1'b0;
      left_fin_q  <= 1'b0;
      right_fin_q <= 1'b0;
      right_cap_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      count_q     <= count_d;
      have_best_q <= have_best_d;
      prev_fin_q  <= prev_fin_d;
      left_fin_q  <= left_fin_d;
      right_fin_q <= right_fin_d;
      right_cap_q <= right_cap_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    best_ref_q <= best_ref_d;
    prev_q     <= prev_d;
    left_q     <= left_d;
    right_q    <= right_d;
  end

  // Contrast is half the summed neighbor differences, floored, clamped and saturated.
  assign sum  = (CW'(left_q) - CW'(best_q)) + (CW'(right_q) - CW'(best_q));
  assign half = sum >>> 1;

  always_comb begin
    if (sum[CW-1] || (sum == '0)) begin
      measured = '0;
    end else if (|half[CW-1:cmfd_pkg::ConfW]) begin
      measured = cmfd_pkg::ConfMax;
    end else begin
      measured = half[cmfd_pkg::ConfW-1:0];
    end
  end

  assign idx_ext  = FiW'(best_idx_q);
  assign best_ext = XW'(best_q);

  always_comb begin
    result_o          = '0;
    result_o.overflow = ovf_q;
    result_o.confidence_kind = cmfd_pkg::CONF_NONE;
    if (have_best_q) begin
      result_o.focus_valid     = 1'b1;
      result_o.focus_idx       = idx_ext[cmfd_pkg::IdxW-1:0];
      result_o.focus_reference = best_ref_q;
      result_o.focus_metric    = best_ext[cmfd_pkg::FocMetricW-1:0];
      if (left_fin_q && right_cap_q && right_fin_q) begin
        result_o.confidence      = measured;
        result_o.confidence_kind = cmfd_pkg::CONF_MEASURED;
      end else begin
        result_o.confidence      = cmfd_pkg::FallbackConf;
        result_o.confidence_kind = cmfd_pkg::CONF_FALLBACK;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish |=> (count_q == '0) && !have_best_q && !ovf_q)
    else $error("tracker state not cleared after end of curve");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> (best_idx_q < count_q))
    else $error("best index not below point count");

  a_right_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_cap_q |-> have_best_q && (count_q > best_idx_q + PcW'(1) || count_q == best_idx_q + PcW'(2) || count_q != '0))
    else $error("right neighbor captured without a minimum");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("point count beyond capacity");
`endif

endmodule

### rtl/curve_minimum_focus_detect.sv
// Top level of the curve minimum focus detector: input stage, tracker and result register.
//
//  channel  | dir | tdata / tuser
//  s_axis   | in  | curve points and end markers, tuser is the item kind
//  m_axis   | out | one focus result per end marker
//
// One item is taken every cycle unless an end marker is held in the input stage; a result
// becomes valid once its end marker has passed the input register, then the result register.
// The tracker state updates from the input register in a single pass per point.
// A stalled result holds only end markers in the input stage; points keep flowing.
// Reset clears the tracker and both valid flags.
module curve_minimum_focus_detect #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned METRIC_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // metric, finite flag, reference position, zero fill
  input  logic [((METRIC_WIDTH+33+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // focus_valid, focus_idx, focus_reference, focus_metric, confidence,
  // confidence_kind, overflow, zero fill
  output logic [cmfd_pkg::OutTdataW-1:0]    m_axis_tdata
);

  localparam int unsigned RefLsb = METRIC_WIDTH + 1;

  logic                           a_valid_q, a_valid_d;
  cmfd_pkg::kind_e                a_kind_q;
  logic signed [METRIC_WIDTH-1:0] a_metric_q;
  logic                           a_fin_q;
  logic signed [cmfd_pkg::RefW-1:0] a_ref_q;
  logic                           in_go;
  logic                           out_free;
  logic                           a_go;
  cmfd_pkg::ctrl_t                ctrl;
  cmfd_pkg::result_t              res;
  cmfd_pkg::result_t              res_q;
  logic                           m_valid_q, m_valid_d;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign a_go          = a_valid_q && ((a_kind_q == cmfd_pkg::KIND_POINT) || out_free);
  assign s_axis_tready = !a_valid_q || a_go;
  assign in_go         = s_axis_tvalid && s_axis_tready;

  assign ctrl.point  = a_go && (a_kind_q == cmfd_pkg::KIND_POINT);
  assign ctrl.finish = a_go && (a_kind_q == cmfd_pkg::KIND_END);

  assign a_valid_d = in_go || (a_valid_q && !a_go);

  always_comb begin
    m_valid_d = m_valid_q;
    if (ctrl.finish) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      a_kind_q   <= cmfd_pkg::kind_e'(s_axis_tuser);
      a_metric_q <= s_axis_tdata[METRIC_WIDTH-1:0];
      a_fin_q    <= s_axis_tdata[METRIC_WIDTH];
      a_ref_q    <= s_axis_tdata[RefLsb +: cmfd_pkg::RefW];
    end
    if (ctrl.finish) begin
      res_q <= res;
    end
  end

  cmfd_tracker #(
    .MAX_POINTS   (MAX_POINTS),
    .METRIC_WIDTH (METRIC_WIDTH)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .metric_i    (a_metric_q),
    .finite_i    (a_fin_q),
    .reference_i (a_ref_q),
    .result_o    (res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0,
                          res_q.overflow,
                          res_q.confidence_kind,
                          res_q.confidence,
                          res_q.focus_metric,
                          res_q.focus_reference,
                          res_q.focus_idx,
                          res_q.focus_valid};

`ifndef NO_ASSERTIONS
  a_out_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |=> m_axis_tvalid)
    else $error("end of curve did not produce a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> !m_valid_q || m_axis_tready)
    else $error("result register overwritten while stalled");

  a_invalid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[109:108] == cmfd_pkg::CONF_NONE)
    else $error("invalid result carries a confidence kind");
`endif

endmodule
